[rtl/core/oaht_pkg.sv]
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-addressed hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int unsigned BUCKET_COUNT = 256;
  localparam int unsigned IDX_W        = $clog2(BUCKET_COUNT);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned VALUE_BITS   = 32;

  localparam logic [CNT_W-1:0] FILL_LIMIT_RESET = CNT_W'(128);

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_ABSENT  = 2'd1,
    STATUS_PRESENT = 2'd2,
    STATUS_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef enum logic [0:0] {
    REG_FILL_LIMIT = 1'b0
  } reg_idx_e;

  typedef struct packed {
    mode_e                 mode;
    logic [KEY_BITS-1:0]   key;
    logic [31:0]           key_hash;
    logic [VALUE_BITS-1:0] value_in;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [VALUE_BITS-1:0] value_out;
    logic [CNT_W-1:0]      probes;
    logic [IDX_W-1:0]      bucket;
  } res_t;

  typedef struct packed {
    mark_e                 mark;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
  } mem_req_t;

endpackage

[rtl/core/oaht_store.sv]
// ----------------------------------------------------------------------------
// oaht_store
// Bucket memory with one write and one registered read port per cycle, plus
// per-bucket written flags so that every bucket reads as empty after reset.
// ----------------------------------------------------------------------------
module oaht_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oaht_pkg::mem_req_t req_i,
  output oaht_pkg::entry_t   rd_entry_o
);
  import oaht_pkg::*;

  entry_t                  mem_q [BUCKET_COUNT];
  entry_t                  rd_data_q;
  logic [BUCKET_COUNT-1:0] written_q;
  logic                    rd_written_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_entry;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        written_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_written_q <= written_q[req_i.rd_addr];
      end
    end
  end

  // A bucket that was never written holds garbage, so its mark reads as empty.
  always_comb begin
    rd_entry_o = rd_data_q;
    if (!rd_written_q) begin
      rd_entry_o.mark = MARK_EMPTY;
    end
  end

endmodule

[rtl/core/oaht_ctrl.sv]
// ----------------------------------------------------------------------------
// oaht_ctrl
// Probe walk sequencer: issues one bucket read per cycle along the triangular
// sequence, evaluates the returned bucket, then commits the result.
// ----------------------------------------------------------------------------
module oaht_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [oaht_pkg::CNT_W-1:0]  fill_limit_i,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  oaht_pkg::req_t              req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output oaht_pkg::res_t              res_o,
  output oaht_pkg::mem_req_t          mem_req_o,
  input  oaht_pkg::entry_t            rd_entry_i
);
  import oaht_pkg::*;

  state_e                state_q, state_d;
  req_t                  item_q;
  logic                  full_q;
  logic [IDX_W-1:0]      chk_pos_q, chk_pos_d;
  logic [IDX_W-1:0]      chk_n_q, chk_n_d;
  logic [IDX_W-1:0]      nxt_pos_q, nxt_pos_d;
  logic                  slot_vld_q, slot_vld_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  logic                  slot_tomb_q, slot_tomb_d;
  logic                  found_vld_q, found_vld_d;
  logic [IDX_W-1:0]      found_q, found_d;
  logic [VALUE_BITS-1:0] found_val_q, found_val_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      occ_q, occ_d;
  logic [CNT_W-1:0]      tomb_q, tomb_d;

  logic accept;
  logic full_now;
  logic hit, empty, tomb, last, walk_end;
  logic fire;

  assign accept   = req_valid_i && req_ready_o;
  assign full_now = (req_i.mode == MODE_INSERT) && ((occ_q - tomb_q) >= fill_limit_i);
  assign fire     = res_valid_o && res_ready_i;

  assign empty    = rd_entry_i.mark == MARK_EMPTY;
  assign tomb     = rd_entry_i.mark == MARK_TOMB;
  assign hit      = (rd_entry_i.mark == MARK_LIVE) && (rd_entry_i.key == item_q.key);
  assign last     = chk_n_q == IDX_W'(BUCKET_COUNT - 1);
  assign walk_end = hit || empty || last;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = full_now ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Walk bookkeeping. The read for the next bucket is issued while the
  // current one is checked; the data of a read past the end of the walk is ignored.
  always_comb begin
    chk_pos_d   = chk_pos_q;
    chk_n_d     = chk_n_q;
    nxt_pos_d   = nxt_pos_q;
    slot_vld_d  = slot_vld_q;
    slot_d      = slot_q;
    slot_tomb_d = slot_tomb_q;
    found_vld_d = found_vld_q;
    found_d     = found_q;
    found_val_d = found_val_q;
    count_d     = count_q;
    case (state_q)
      ST_IDLE: begin
        chk_pos_d   = req_i.key_hash[IDX_W-1:0];
        chk_n_d     = '0;
        nxt_pos_d   = req_i.key_hash[IDX_W-1:0] + IDX_W'(1);
        slot_vld_d  = 1'b0;
        found_vld_d = 1'b0;
      end
      ST_WALK: begin
        chk_pos_d = nxt_pos_q;
        chk_n_d   = chk_n_q + IDX_W'(1);
        nxt_pos_d = nxt_pos_q + chk_n_q + IDX_W'(2);
        if (!slot_vld_q && (empty || tomb)) begin
          slot_vld_d  = 1'b1;
          slot_d      = chk_pos_q;
          slot_tomb_d = tomb;
        end
        if (hit) begin
          found_vld_d = 1'b1;
          found_d     = chk_pos_q;
          found_val_d = rd_entry_i.value;
          count_d     = {1'b0, chk_n_q} + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Outputs: handshakes, memory access, result and counter updates.
  always_comb begin
    req_ready_o        = state_q == ST_IDLE;
    res_valid_o        = state_q == ST_FINISH;
    mem_req_o          = '0;
    mem_req_o.rd_en    = (state_q == ST_WALK) || accept;
    mem_req_o.rd_addr  = (state_q == ST_WALK) ? nxt_pos_q : req_i.key_hash[IDX_W-1:0];
    res_o              = '0;
    res_o.status       = STATUS_ABSENT;
    occ_d              = occ_q;
    tomb_d             = tomb_q;
    if (state_q == ST_FINISH) begin
      if (full_q) begin
        res_o.status = STATUS_FULL;
      end else begin
        case (item_q.mode)
          MODE_FIND: begin
            if (found_vld_q) begin
              res_o.status    = STATUS_DONE;
              res_o.value_out = found_val_q;
              res_o.bucket    = found_q;
            end
          end
          MODE_INSERT: begin
            if (found_vld_q) begin
              res_o.status = STATUS_PRESENT;
              res_o.bucket = found_q;
            end else if (!slot_vld_q) begin
              res_o.status = STATUS_FULL;
            end else begin
              res_o.status             = STATUS_DONE;
              res_o.bucket             = slot_q;
              mem_req_o.wr_en          = fire;
              mem_req_o.wr_addr        = slot_q;
              mem_req_o.wr_entry.mark  = MARK_LIVE;
              mem_req_o.wr_entry.key   = item_q.key;
              mem_req_o.wr_entry.value = item_q.value_in;
              if (fire) begin
                if (slot_tomb_q) begin
                  tomb_d = tomb_q - CNT_W'(1);
                end else begin
                  occ_d = occ_q + CNT_W'(1);
                end
              end
            end
          end
          MODE_ERASE: begin
            if (found_vld_q) begin
              res_o.status             = STATUS_DONE;
              res_o.bucket             = found_q;
              mem_req_o.wr_en          = fire;
              mem_req_o.wr_addr        = found_q;
              mem_req_o.wr_entry.mark  = MARK_TOMB;
              mem_req_o.wr_entry.key   = item_q.key;
              mem_req_o.wr_entry.value = found_val_q;
              if (fire) begin
                tomb_d = tomb_q + CNT_W'(1);
              end
            end
          end
          MODE_COUNT: begin
            if (found_vld_q) begin
              res_o.status = STATUS_DONE;
              res_o.probes = count_q;
              res_o.bucket = found_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_i;
      full_q <= full_now;
    end
    chk_pos_q   <= chk_pos_d;
    chk_n_q     <= chk_n_d;
    nxt_pos_q   <= nxt_pos_d;
    slot_q      <= slot_d;
    slot_tomb_q <= slot_tomb_d;
    found_q     <= found_d;
    found_val_q <= found_val_d;
    count_q     <= count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_vld_q  <= 1'b0;
      found_vld_q <= 1'b0;
      occ_q       <= '0;
      tomb_q      <= '0;
    end else begin
      state_q     <= state_d;
      slot_vld_q  <= slot_vld_d;
      found_vld_q <= found_vld_d;
      occ_q       <= occ_d;
      tomb_q      <= tomb_d;
    end
  end

endmodule

[rtl/core/open_addressing_hash_table.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open-addressed key/value table with triangular probing and tombstones.
// ----------------------------------------------------------------------------
// Usage: a request beat (in_valid_i/in_ready_o, in_data_i) carries a mode
// (find, insert, erase, probe count), a key, its externally computed hash and
// an insert value. Exactly one result beat (out_valid_o/out_ready_i,
// out_data_o) follows each request, in order.
// Walk: an item reads one bucket per cycle along its probe sequence, from one
// up to all 256 buckets; an insert refused by the fill limit walks no bucket.
// The bucket memory has one read and one write port. One item is in work at
// a time; the next item is accepted while the previous result still waits in
// the output register.
// Reset: all buckets read as empty at once through per-bucket written flags,
// the occupied-bucket and tombstone counts clear and fill_limit returns to 128. No
// clearing pass is needed.
// A stalled receiver holds the result in the output register; the walk of
// the following item still runs but its commit waits for a free register.
// The user must write fill_limit over APB only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module open_addressing_hash_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  oaht_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output oaht_pkg::res_t  out_data_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import oaht_pkg::*;

  logic [CNT_W-1:0] fill_limit_q;
  logic             out_valid_q;
  res_t             out_data_q;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  mem_req_t         mem_req;
  entry_t           rd_entry;
  logic             cfg_wr;
  reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_FILL_LIMIT: prdata = 32'(fill_limit_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= FILL_LIMIT_RESET;
    end else if (cfg_wr && (reg_idx == REG_FILL_LIMIT)) begin
      fill_limit_q <= pwdata[CNT_W-1:0];
    end
  end

  oaht_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .rd_entry_o (rd_entry)
  );

  oaht_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fill_limit_i (fill_limit_q),
    .req_valid_i  (in_valid_i),
    .req_ready_o  (in_ready_o),
    .req_i        (in_data_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .rd_entry_i   (rd_entry)
  );

  // Output register: a new result loads when the register is empty or is
  // being drained in the same cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
